// ===== rtl/rmtc_pkg.sv =====
// ----------------------------------------------------------------------------
// rmtc_pkg
// Shared widths, codes and types of the repeat-match trigger capture block.
// ----------------------------------------------------------------------------
package rmtc_pkg;

  localparam int SAMPLE_W    = 9;
  localparam int OP_W        = 2;
  localparam int IDX_W       = 7;
  localparam int STATUS_W    = 3;
  localparam int POS_W       = 8;
  localparam int THRESH_W    = 9;
  localparam int CHECK_W     = 8;
  localparam int LIMIT_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (POS_W + 1 + SAMPLE_W);

  // Item kinds.
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_REARM  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REARMED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_READ     = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_COUNT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_NEVER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_ENABLE  = 3'd4;

  // Configuration reset values.
  localparam logic [THRESH_W-1:0] RST_ERROR_THRESHOLD = 9'd8;
  localparam logic [CHECK_W-1:0]  RST_CHECK_COUNT     = 8'd5;
  localparam logic [LIMIT_W-1:0]  RST_RESET_LIMIT     = 16'd64;

  typedef struct packed {
    logic [THRESH_W-1:0] error_threshold;
    logic [CHECK_W-1:0]  check_count;
    logic [LIMIT_W-1:0]  reset_limit;
    logic                reset_never;
    logic                trigger_enable;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                store;
  } step_ctl_t;

endpackage

// ===== rtl/repeat_match_trigger_capture.sv =====
// Throughput: one item per cycle, sustained, while neither side stalls; either side
// may stall freely. An accepted item is registered into the decision stage, is
// decided there, and its result is registered into the output register, from
// which it transfers. The store is read once per item and the read address
// comes from the decision on the item before.
// Reset clears control state and loads configuration defaults; the store
// needs no clearing pass, a high-water mark gives zero for unwritten entries.
// ----------------------------------------------------------------------------
// repeat_match_trigger_capture
// Capture buffer whose trigger requires the leading samples of a new frame to
// match the previous frame within a threshold, with a failure timeout.
// ----------------------------------------------------------------------------
module repeat_match_trigger_capture #(
  parameter int FRAME_SAMPLES = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rmtc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rmtc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [rmtc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // sample[8:0], read_index[15:9]
  input  logic [rmtc_pkg::OP_W-1:0]           s_axis_tuser,   // op[1:0]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [rmtc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // write_position[7:0],
                                                              // frame_full[8],
                                                              // read_data[17:9], zero[23:18]
  output logic [rmtc_pkg::STATUS_W-1:0]       m_axis_tuser    // status[2:0]
);

  localparam int FILL_W = $clog2(FRAME_SAMPLES + 1);
  localparam int ADDR_W = $clog2(FRAME_SAMPLES);

  // Configuration registers.
  rmtc_pkg::cfg_t cfg;

  // Architectural state.
  logic [FILL_W-1:0]            fill;
  logic [FILL_W-1:0]            high_water;
  logic                         prev_valid;
  logic [rmtc_pkg::LIMIT_W-1:0] fail_count;

  // Sample store.
  logic [rmtc_pkg::SAMPLE_W-1:0] mem [FRAME_SAMPLES];
  logic [rmtc_pkg::SAMPLE_W-1:0] mem_q;
  logic [ADDR_W-1:0]             rd_addr;
  logic [ADDR_W-1:0]             wr_addr;
  logic                          wr_go;
  logic                          fwd_hit;
  logic [rmtc_pkg::SAMPLE_W-1:0] fwd_data;

  // Decision stage.
  logic                          s1_valid;
  logic [rmtc_pkg::OP_W-1:0]     s1_op;
  logic [rmtc_pkg::SAMPLE_W-1:0] s1_sample;
  logic [rmtc_pkg::IDX_W-1:0]    s1_ridx;
  logic [rmtc_pkg::SAMPLE_W-1:0] s1_stored;
  rmtc_pkg::step_ctl_t           ctl;
  logic [FILL_W-1:0]             fill_next;
  logic                          prev_valid_next;
  logic [rmtc_pkg::LIMIT_W-1:0]  fail_count_next;
  logic [rmtc_pkg::SAMPLE_W-1:0] step_rdata;
  logic [FILL_W-1:0]             fill_ahead;
  logic [FILL_W+rmtc_pkg::POS_W-1:0] pos_ext;

  // Output register.
  logic                          out_valid;
  logic [rmtc_pkg::STATUS_W-1:0] out_status;
  logic [rmtc_pkg::POS_W-1:0]    out_pos;
  logic                          out_full;
  logic [rmtc_pkg::SAMPLE_W-1:0] out_rdata;

  logic in_fire;
  logic s1_fire;

  assign s1_fire       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.error_threshold <= rmtc_pkg::RST_ERROR_THRESHOLD;
      cfg.check_count     <= rmtc_pkg::RST_CHECK_COUNT;
      cfg.reset_limit     <= rmtc_pkg::RST_RESET_LIMIT;
      cfg.reset_never     <= 1'b0;
      cfg.trigger_enable  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rmtc_pkg::REG_ERROR_THRESHOLD: cfg.error_threshold <= cfg_data[rmtc_pkg::THRESH_W-1:0];
        rmtc_pkg::REG_CHECK_COUNT:     cfg.check_count     <= cfg_data[rmtc_pkg::CHECK_W-1:0];
        rmtc_pkg::REG_RESET_LIMIT:     cfg.reset_limit     <= cfg_data[rmtc_pkg::LIMIT_W-1:0];
        rmtc_pkg::REG_RESET_NEVER:     cfg.reset_never     <= cfg_data[0];
        rmtc_pkg::REG_TRIGGER_ENABLE:  cfg.trigger_enable  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // The next item's read address follows the fill position as the item now
  // in the decision stage will leave it.
  assign fill_ahead = s1_fire ? fill_next : fill;

  always_comb begin
    if (s_axis_tuser == rmtc_pkg::OP_READ) begin
      rd_addr = ADDR_W'(s_axis_tdata[rmtc_pkg::IN_TDATA_W-1:rmtc_pkg::SAMPLE_W]);
    end else if (fill_ahead == FILL_W'(FRAME_SAMPLES)) begin
      rd_addr = '0;
    end else begin
      rd_addr = ADDR_W'(fill_ahead);
    end
  end

  assign wr_addr = ADDR_W'(fill);
  assign wr_go   = s1_fire && ctl.store;

  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem[wr_addr] <= s1_sample;
    end
    if (in_fire) begin
      mem_q <= mem[rd_addr];
    end
  end

  // A write and a read of the same entry at one edge: the read takes the new
  // sample instead of the old memory contents.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (in_fire) begin
      fwd_hit <= wr_go && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_data <= s1_sample;
    end
  end

  assign s1_stored = fwd_hit ? fwd_data : mem_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op     <= s_axis_tuser;
      s1_sample <= s_axis_tdata[rmtc_pkg::SAMPLE_W-1:0];
      s1_ridx   <= s_axis_tdata[rmtc_pkg::IN_TDATA_W-1:rmtc_pkg::SAMPLE_W];
    end
  end

  rmtc_step #(
    .FRAME_SAMPLES (FRAME_SAMPLES)
  ) u_step (
    .op              (s1_op),
    .sample          (s1_sample),
    .read_index      (s1_ridx),
    .stored          (s1_stored),
    .fill            (fill),
    .prev_valid      (prev_valid),
    .fail_count      (fail_count),
    .high_water      (high_water),
    .cfg             (cfg),
    .ctl             (ctl),
    .fill_next       (fill_next),
    .prev_valid_next (prev_valid_next),
    .fail_count_next (fail_count_next),
    .read_data       (step_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      high_water <= '0;
      prev_valid <= 1'b0;
      fail_count <= '0;
    end else if (s1_fire) begin
      fill       <= fill_next;
      prev_valid <= prev_valid_next;
      fail_count <= fail_count_next;
      // Writes always go to the next entry of a filled prefix, so the mark
      // only moves when the write lands exactly on it.
      if (ctl.store && (fill == high_water)) begin
        high_water <= high_water + 1'b1;
      end
    end
  end

  assign pos_ext = {{rmtc_pkg::POS_W{1'b0}}, fill_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_status <= ctl.status;
      out_pos    <= pos_ext[rmtc_pkg::POS_W-1:0];
      out_full   <= (fill_next == FILL_W'(FRAME_SAMPLES));
      out_rdata  <= step_rdata;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {{rmtc_pkg::OUT_PAD_W{1'b0}}, out_rdata, out_full, out_pos};

endmodule

// ===== rtl/rmtc_step.sv =====
// ----------------------------------------------------------------------------
// rmtc_step
// Decision logic for one item: trigger timeout, match check against the
// stored frame, rearm, fill update and read-back selection.
// ----------------------------------------------------------------------------
module rmtc_step #(
  parameter int FRAME_SAMPLES = 128
) (
  input  logic [rmtc_pkg::OP_W-1:0]                     op,
  input  logic [rmtc_pkg::SAMPLE_W-1:0]                 sample,
  input  logic [rmtc_pkg::IDX_W-1:0]                    read_index,
  input  logic [rmtc_pkg::SAMPLE_W-1:0]                 stored,
  input  logic [$clog2(FRAME_SAMPLES + 1)-1:0]          fill,
  input  logic                                          prev_valid,
  input  logic [rmtc_pkg::LIMIT_W-1:0]                  fail_count,
  input  logic [$clog2(FRAME_SAMPLES + 1)-1:0]          high_water,
  input  rmtc_pkg::cfg_t                                cfg,
  output rmtc_pkg::step_ctl_t                           ctl,
  output logic [$clog2(FRAME_SAMPLES + 1)-1:0]          fill_next,
  output logic                                          prev_valid_next,
  output logic [rmtc_pkg::LIMIT_W-1:0]                  fail_count_next,
  output logic [rmtc_pkg::SAMPLE_W-1:0]                 read_data
);

  localparam int FILL_W  = $clog2(FRAME_SAMPLES + 1);
  localparam int CHK_W   = (FILL_W > rmtc_pkg::CHECK_W) ? FILL_W : rmtc_pkg::CHECK_W;
  localparam int RIDX_W  = (FILL_W > rmtc_pkg::IDX_W) ? FILL_W : rmtc_pkg::IDX_W;

  logic                          full;
  logic                          in_check;
  logic                          read_ok;
  logic [rmtc_pkg::SAMPLE_W-1:0] gap;

  assign full     = (fill == FILL_W'(FRAME_SAMPLES));
  assign in_check = (CHK_W'(fill) < CHK_W'(cfg.check_count));
  assign gap      = (sample >= stored) ? (sample - stored) : (stored - sample);

  // Entries below the high-water mark have been written at least once; reads
  // of the rest return zero, as the store itself is never cleared.
  assign read_ok  = (RIDX_W'(read_index) < RIDX_W'(high_water));

  always_comb begin
    ctl.status      = rmtc_pkg::ST_IGNORED;
    ctl.store       = 1'b0;
    fill_next       = fill;
    prev_valid_next = prev_valid;
    fail_count_next = fail_count;
    read_data       = '0;
    unique case (op)
      rmtc_pkg::OP_SAMPLE: begin
        if (!full) begin
          ctl.status = rmtc_pkg::ST_STORED;
          if (cfg.trigger_enable) begin
            if (!cfg.reset_never && (fail_count >= cfg.reset_limit)) begin
              fail_count_next = '0;
              prev_valid_next = 1'b0;
              fill_next       = '0;
              ctl.status      = rmtc_pkg::ST_TIMEOUT;
            end else if (prev_valid && in_check && (gap > cfg.error_threshold)) begin
              if (fail_count != '1) begin
                fail_count_next = fail_count + 1'b1;
              end
              fill_next  = '0;
              ctl.status = rmtc_pkg::ST_MISMATCH;
            end
          end
          if (ctl.status == rmtc_pkg::ST_STORED) begin
            ctl.store = 1'b1;
            fill_next = fill + 1'b1;
          end
        end
      end
      rmtc_pkg::OP_REARM: begin
        ctl.status = rmtc_pkg::ST_REARMED;
        if (full) begin
          prev_valid_next = 1'b1;
          fail_count_next = '0;
          fill_next       = '0;
        end
      end
      rmtc_pkg::OP_READ: begin
        ctl.status = rmtc_pkg::ST_READ;
        if (read_ok) begin
          read_data = stored;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for repeat_match_trigger_capture
// Drives sample, rearm and read transfers with random gaps and back-pressure.
// Each result is checked field by field against a cycle-free prediction of
// the capture store, fill position, match trigger and failure counter. The
// run steps through several register settings and ends with a run of failed
// matches that is then cleared by the failure timeout.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import rmtc_pkg::*;

typedef struct packed {
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    write_position;
  logic                frame_full;
  logic [SAMPLE_W-1:0] read_data;
} capture_reply_t;

class trigger_scoreboard #(int FRAME = 128);
  logic [SAMPLE_W-1:0] store [FRAME];
  int unsigned         fill;
  bit                  prev_valid;
  logic [LIMIT_W-1:0]  fail_count;
  logic [THRESH_W-1:0] thr;
  logic [CHECK_W-1:0]  chk;
  logic [LIMIT_W-1:0]  limit;
  bit                  never;
  bit                  trig;
  capture_reply_t      due_replies[$];
  int                  errors;

  function new();
    foreach (store[i]) store[i] = '0;
    fill       = 0;
    prev_valid = 1'b0;
    fail_count = '0;
    thr        = RST_ERROR_THRESHOLD;
    chk        = RST_CHECK_COUNT;
    limit      = RST_RESET_LIMIT;
    never      = 1'b0;
    trig       = 1'b1;
    errors     = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ERROR_THRESHOLD: thr   = data[THRESH_W-1:0];
      REG_CHECK_COUNT:     chk   = data[CHECK_W-1:0];
      REG_RESET_LIMIT:     limit = data[LIMIT_W-1:0];
      REG_RESET_NEVER:     never = data[0];
      REG_TRIGGER_ENABLE:  trig  = data[0];
      default: ;
    endcase
  endfunction

  function int pending();
    return due_replies.size();
  endfunction

  // Advances the capture state by one accepted transfer and queues its reply.
  function void take_item(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] smp,
                          logic [IDX_W-1:0] ridx);
    capture_reply_t r;
    int gap;
    r = '0;
    r.status = ST_IGNORED;
    case (op)
      OP_SAMPLE: begin
        if (fill < FRAME) begin
          r.status = ST_STORED;
          gap = int'(smp) - int'(store[fill]);
          if (gap < 0) gap = -gap;
          if (trig) begin
            // The timeout is checked first, even without a previous frame.
            if (!never && fail_count >= limit) begin
              fail_count = '0;
              prev_valid = 1'b0;
              fill       = 0;
              r.status   = ST_TIMEOUT;
            end else if (prev_valid && fill < chk && gap > int'(thr)) begin
              if (fail_count != '1) fail_count++;
              fill     = 0;
              r.status = ST_MISMATCH;
            end
          end
          if (r.status == ST_STORED) begin
            store[fill] = smp;
            fill++;
          end
        end
      end
      OP_REARM: begin
        r.status = ST_REARMED;
        if (fill >= FRAME) begin
          prev_valid = 1'b1;
          fail_count = '0;
          fill       = 0;
        end
      end
      OP_READ: begin
        r.status = ST_READ;
        if (ridx < FRAME) r.read_data = store[ridx];
      end
      default: ;
    endcase
    r.write_position = fill[POS_W-1:0];
    r.frame_full     = (fill >= FRAME);
    due_replies.push_back(r);
  endfunction

  task report(string msg);
    errors++;
    $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task match_reply(capture_reply_t got, logic [OUT_PAD_W-1:0] pad);
    capture_reply_t want;
    if (due_replies.size() == 0) begin
      report($sformatf("unexpected result, status %0d", got.status));
      return;
    end
    want = due_replies.pop_front();
    if (got.status !== want.status)
      report($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.write_position !== want.write_position)
      report($sformatf("write_position %0d, want %0d", got.write_position,
                       want.write_position));
    if (got.frame_full !== want.frame_full)
      report($sformatf("frame_full %0b, want %0b", got.frame_full, want.frame_full));
    if (got.read_data !== want.read_data)
      report($sformatf("read_data %0d, want %0d", got.read_data, want.read_data));
    if (pad !== '0)
      report($sformatf("padding bits %b, want zero", pad));
  endtask
endclass

module tb;

  localparam int FRAME_SAMPLES = 128;
  localparam int IDLE_PCT      = 13;
  localparam int PHASE_ITEMS   = 115;
  localparam int FAIL_ATTEMPTS = 30;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data      = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]        s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  bit tx_idle_on     = 1'b1;
  bit rx_idle_on     = 1'b1;
  int rx_hold_cycles = 0;

  trigger_scoreboard #(FRAME_SAMPLES) sb;
  capture_reply_t seen;

  repeat_match_trigger_capture #(
    .FRAME_SAMPLES(FRAME_SAMPLES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_cycles = rx_hold_cycles - 1;
    end else begin
      m_axis_tready <= !(rx_idle_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.status         = m_axis_tuser;
      seen.write_position = m_axis_tdata[POS_W-1:0];
      seen.frame_full     = m_axis_tdata[POS_W];
      seen.read_data      = m_axis_tdata[POS_W+SAMPLE_W:POS_W+1];
      sb.match_reply(seen, m_axis_tdata[OUT_TDATA_W-1:OUT_TDATA_W-OUT_PAD_W]);
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] smp,
                           input logic [IDX_W-1:0] ridx);
    @(negedge clk);
    while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {ridx, smp};
    do @(posedge clk); while (!s_axis_tready);
    sb.take_item(op, smp, ridx);
  endtask

  // Stops offering and waits until every queued reply has been checked.
  task automatic flush_replies();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(input int thr, input int chk, input int lim,
                            input bit nev, input bit trg);
    write_reg(REG_ERROR_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_CHECK_COUNT, CFG_DATA_W'(chk));
    write_reg(REG_RESET_LIMIT, CFG_DATA_W'(lim));
    write_reg(REG_RESET_NEVER, CFG_DATA_W'(nev));
    write_reg(REG_TRIGGER_ENABLE, CFG_DATA_W'(trg));
  endtask

  // A value gap away from base. A far value keeps the whole gap where the
  // range allows; a near one may be clamped, which only brings it closer.
  function automatic logic [SAMPLE_W-1:0] sample_near(logic [SAMPLE_W-1:0] base,
                                                      int gap, bit far);
    int v;
    bit up;
    if (far)
      up = (int'(base) + gap <= 511) ? 1'b1 : (int'(base) >= gap) ? 1'b0 : (base < 256);
    else
      up = $urandom_range(0, 1);
    v = up ? int'(base) + gap : int'(base) - gap;
    if (v > 511) v = 511;
    if (v < 0) v = 0;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic random_item(input int bad_pct);
    int roll;
    int gap;
    logic [OP_W-1:0]     op;
    logic [SAMPLE_W-1:0] smp;
    logic [IDX_W-1:0]    ridx;
    logic [SAMPLE_W-1:0] base;
    roll = $urandom_range(0, 99);
    smp  = SAMPLE_W'($urandom);
    ridx = IDX_W'($urandom);
    op   = OP_SAMPLE;
    if (sb.fill >= FRAME_SAMPLES) begin
      if (roll < 70) op = OP_REARM;
      else if (roll < 80) op = OP_SAMPLE;
      else if (roll < 95) op = OP_READ;
      else op = OP_UNUSED;
    end else if (roll < 85) begin
      // Mostly follow the previous frame so that the trigger gets through.
      base = sb.store[sb.fill];
      roll = $urandom_range(0, 99);
      if (roll >= bad_pct) begin
        gap = ($urandom_range(0, 4) == 0) ? int'(sb.thr) : $urandom_range(0, sb.thr);
        smp = sample_near(base, gap, 1'b0);
      end else if (roll >= bad_pct / 2) begin
        gap = int'(sb.thr) + 1 + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60));
        smp = sample_near(base, gap, 1'b1);
      end
    end else if (roll < 89) begin
      op = OP_REARM;
    end else if (roll < 97) begin
      op = OP_READ;
    end else begin
      op = OP_UNUSED;
    end
    send_item(op, smp, ridx);
  endtask

  initial begin
    int thr;
    int chk;
    int lim;
    int bad;
    bit nev;
    bit trg;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings.
    send_item(OP_READ, '0, '0);
    send_item(OP_READ, '1, '1);
    send_item(OP_UNUSED, '1, '1);
    send_item(OP_REARM, '0, '0);
    send_item(OP_SAMPLE, '1, '0);
    send_item(OP_SAMPLE, '0, '1);
    send_item(OP_READ, '0, 7'd0);
    send_item(OP_READ, '0, 7'd1);
    while (sb.fill < FRAME_SAMPLES) send_item(OP_SAMPLE, SAMPLE_W'($urandom), '0);
    send_item(OP_SAMPLE, 9'd100, '0);
    send_item(OP_READ, '0, '1);
    send_item(OP_REARM, '0, '0);
    // A sample exactly at the threshold passes; a rearm on a partial frame
    // changes nothing; one step past the threshold restarts the frame.
    send_item(OP_SAMPLE, sample_near(sb.store[0], int'(sb.thr), 1'b1), '0);
    send_item(OP_REARM, '0, '0);
    send_item(OP_SAMPLE, sample_near(sb.store[1], int'(sb.thr) + 1, 1'b1), '0);
    send_item(OP_UNUSED, '0, '0);
    flush_replies();
    // A zero failure limit clears on every sample.
    write_reg(REG_RESET_LIMIT, '0);
    send_item(OP_SAMPLE, '1, '0);
    send_item(OP_SAMPLE, '0, '0);
    flush_replies();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin thr = 0;   chk = 128; lim = 65535; nev = 0; trg = 1; bad = 0;  end
        1: begin thr = 511; chk = 128; lim = 0;     nev = 1; trg = 1; bad = 30; end
        2: begin thr = 2;   chk = 3;   lim = 1;     nev = 0; trg = 1; bad = 20; end
        3: begin thr = 8;   chk = 0;   lim = 0;     nev = 0; trg = 1; bad = 5;  end
        4: begin
          thr = $urandom_range(0, 20);
          chk = $urandom_range(1, 8);
          lim = $urandom_range(0, 6);
          nev = 0;
          trg = 0;
          bad = 20;
        end
        default: begin
          thr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 24);
          chk = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 128) : $urandom_range(0, 12);
          lim = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 10);
          nev = ($urandom_range(0, 3) == 0);
          trg = ($urandom_range(0, 4) != 0);
          case ($urandom_range(0, 3))
            0: bad = 0;
            1: bad = 3;
            2: bad = 10;
            default: bad = 25;
          endcase
        end
      endcase
      set_config(thr, chk, lim, nev, trg);
      // One phase runs with no gaps at all; another stalls the receiver for
      // long enough that the block backs up into its input.
      tx_idle_on = (ph != 5);
      rx_idle_on = (ph != 5);
      if (ph == 7) rx_hold_cycles = 400;
      repeat (PHASE_ITEMS) random_item(bad);
      flush_replies();
    end

    // Failure timeout after a run of failed matches: capture a frame freely,
    // make it the previous frame, then fail the first position a number of
    // times while the drop is held off. Once the drop is allowed with the
    // limit at that count, the next sample must clear.
    set_config(0, 1, 65535, 1, 0);
    while (sb.fill < FRAME_SAMPLES) send_item(OP_SAMPLE, SAMPLE_W'($urandom), '0);
    send_item(OP_REARM, '0, '0);
    flush_replies();
    write_reg(REG_TRIGGER_ENABLE, CFG_DATA_W'(1));
    repeat (FAIL_ATTEMPTS) send_item(OP_SAMPLE, ~sb.store[0], IDX_W'($urandom));
    flush_replies();
    write_reg(REG_RESET_LIMIT, CFG_DATA_W'(FAIL_ATTEMPTS));
    write_reg(REG_RESET_NEVER, '0);
    send_item(OP_SAMPLE, sb.store[0], '0);
    send_item(OP_READ, '0, '0);

    flush_replies();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== repeat_match_trigger_capture.f =====
rtl/rmtc_pkg.sv
rtl/rmtc_step.sv
rtl/repeat_match_trigger_capture.sv
tb/sv/tb.sv
